// ===== hdl/smbs_pkg.sv =====
// Shared types and constants for the SPI master byte shifter.
package smbs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CPOL     = 2'd0;
  localparam logic [1:0] CFG_CPHA     = 2'd1;
  localparam logic [1:0] CFG_CS_LEVEL = 2'd2;

  localparam int unsigned ByteW = 8;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic cpol;
    logic cpha;
    logic cs_level;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] tx_byte;
    logic [ByteW-1:0] miso_bits;
    logic             end_after;
  } item_t;

  typedef struct packed {
    logic             clock_pin;
    logic             data_out_pin;
    logic             select_pin;
    logic [ByteW-1:0] rx_byte;
    logic             last;
  } res_t;

endpackage

// ===== hdl/smbs_seq.sv =====
// Pin-phase sequencer: holds one byte request and walks its pin states.
module smbs_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  smbs_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smbs_pkg::item_t item_i,
  input  logic           out_adv_i,
  output logic           res_valid_o,
  output smbs_pkg::res_t  res_o
);
  import smbs_pkg::*;

  // Phase codes: select setup, sixteen half bits, select release
  localparam logic [4:0] PH_OPEN      = 5'd0;
  localparam logic [4:0] PH_BIT_FIRST = 5'd1;
  localparam logic [4:0] PH_BIT_END   = 5'd16;
  localparam logic [4:0] PH_CLOSE     = 5'd17;

  logic       busy_q, busy_d;
  logic       open_q, open_d;
  logic       dol_q, dol_d;
  logic [4:0] phase_q, phase_d;
  item_t      item_q;

  logic       emit, ph_last, done, accept, in_bit, first_half, tx_bit, dat, rx_show;
  logic [4:0] ph_off;
  logic [2:0] bit_sel;

  // Decode the current phase
  always_comb begin
    emit       = busy_q && out_adv_i;
    ph_last    = (phase_q == PH_CLOSE) || ((phase_q == PH_BIT_END) && !item_q.end_after);
    done       = emit && ph_last;
    in_ready_o = !busy_q || done;
    accept     = in_valid_i && in_ready_o;
    in_bit     = (phase_q >= PH_BIT_FIRST) && (phase_q <= PH_BIT_END);
    ph_off     = phase_q - PH_BIT_FIRST;
    bit_sel    = ph_off[3:1];
    first_half = ph_off[0] == 1'b0;
    // MSB first: bit index 0 maps to tx_byte[7]
    tx_bit     = item_q.tx_byte[~bit_sel];
    dat        = (in_bit && (item_q.req_type == REQ_WRITE)) ? tx_bit : dol_q;
    rx_show    = ph_last && (item_q.req_type == REQ_READ);
  end

  // Build the pin state of this phase
  always_comb begin
    res_valid_o        = busy_q;
    res_o.data_out_pin = dat;
    res_o.last         = ph_last;
    res_o.rx_byte      = rx_show ? item_q.miso_bits : '0;
    res_o.select_pin   = (phase_q == PH_CLOSE) ? ~cfg_i.cs_level : cfg_i.cs_level;
    if (in_bit) begin
      res_o.clock_pin = first_half ? (cfg_i.cpol ^ cfg_i.cpha) : (cfg_i.cpol ^ ~cfg_i.cpha);
    end else begin
      res_o.clock_pin = cfg_i.cpol;
    end
  end

  // Next state
  always_comb begin
    open_d = open_q;
    if (emit && (phase_q == PH_OPEN)) begin
      open_d = 1'b1;
    end else if (emit && (phase_q == PH_CLOSE)) begin
      open_d = 1'b0;
    end
    dol_d = (emit && in_bit && (item_q.req_type == REQ_WRITE)) ? tx_bit : dol_q;
    busy_d = busy_q;
    phase_d = phase_q;
    if (accept) begin
      busy_d  = 1'b1;
      phase_d = open_d ? PH_BIT_FIRST : PH_OPEN;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (emit) begin
      phase_d = phase_q + 5'd1;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      open_q  <= 1'b0;
      dol_q   <= 1'b0;
      phase_q <= PH_OPEN;
    end else begin
      busy_q  <= busy_d;
      open_q  <= open_d;
      dol_q   <= dol_d;
      phase_q <= phase_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (phase_q <= PH_CLOSE))
    else $error("phase beyond close");
  a_no_close_without_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !item_q.end_after) |-> (phase_q != PH_CLOSE))
    else $error("close phase without end flag");
  a_close_releases : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (phase_q == PH_CLOSE)) |=> !open_q)
    else $error("transaction still open after close");
  a_open_sets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (phase_q == PH_OPEN)) |=> open_q)
    else $error("transaction not open after select setup");
  a_open_only_when_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (phase_q == PH_OPEN)) |-> !open_q)
    else $error("select setup while transaction open");

endmodule

// ===== hdl/smbs_out_reg.sv =====
// Output register for pin-state results with valid/ready handshake.
module smbs_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  smbs_pkg::res_t res_i,
  output logic          out_adv_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output smbs_pkg::res_t res_o
);
  import smbs_pkg::*;

  logic out_valid_q;
  res_t res_q;

  // Advance when empty or when the held result is taken
  assign out_adv_o   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/spi_master_byte_shifter_core.sv =====
// Top level of the SPI master byte shifter (modes 0 to 3, MSB first).
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------------
//  input    | in        | in_valid_i / in_ready_o  | req_type, tx_byte, miso_bits, end_after
//  output   | out       | out_valid_o / out_ready_i| clock_pin, data_out_pin, select_pin,
//           |           |                          | rx_byte, last
//  config   | in        | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One byte request yields 16 to 18 pin states, one per cycle from the phase
// sequencer while the output is not stalled; the next request is taken in the
// cycle its predecessor's last pin state enters the output register.
// Reset clears configuration, the open transaction flag and the held data level.
// A stalled output holds the sequencer; no pin state is dropped or repeated.
module spi_master_byte_shifter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [smbs_pkg::ByteW-1:0]  tx_byte_i,
  input  logic [smbs_pkg::ByteW-1:0]  miso_bits_i,
  input  logic                        end_after_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        clock_pin_o,
  output logic                        data_out_pin_o,
  output logic                        select_pin_o,
  output logic [smbs_pkg::ByteW-1:0]  rx_byte_o,
  output logic                        last_o
);
  import smbs_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  seq_res, out_res;
  logic  seq_valid, out_adv;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CPOL:     cfg_q.cpol     <= cfg_data_i;
        CFG_CPHA:     cfg_q.cpha     <= cfg_data_i;
        CFG_CS_LEVEL: cfg_q.cs_level <= cfg_data_i;
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  // Pack the request
  always_comb begin
    item.req_type  = req_type_i;
    item.tx_byte   = tx_byte_i;
    item.miso_bits = miso_bits_i;
    item.end_after = end_after_i;
  end

  smbs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (item),
    .out_adv_i   (out_adv),
    .res_valid_o (seq_valid),
    .res_o       (seq_res)
  );

  smbs_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (seq_valid),
    .res_i       (seq_res),
    .out_adv_o   (out_adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Unpack the result
  assign clock_pin_o    = out_res.clock_pin;
  assign data_out_pin_o = out_res.data_out_pin;
  assign select_pin_o   = out_res.select_pin;
  assign rx_byte_o      = out_res.rx_byte;
  assign last_o         = out_res.last;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the SPI master byte shifter core.
`timescale 1ns / 1ps

module testbench;
  import smbs_pkg::*;

  // Index that no register answers to
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_PRINTED = 50;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = CFG_CPOL;
  logic             cfg_data_i = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             req_type_i = REQ_WRITE;
  logic [ByteW-1:0] tx_byte_i = '0;
  logic [ByteW-1:0] miso_bits_i = '0;
  logic             end_after_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             clock_pin_o;
  logic             data_out_pin_o;
  logic             select_pin_o;
  logic [ByteW-1:0] rx_byte_o;
  logic             last_o;

  // Shadow of the block's configuration and serial-line state
  cfg_t mode_shadow = '0;
  logic txn_open = 1'b0;
  logic held_mosi = 1'b0;
  res_t expected_pins[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned pins_checked = 0;
  int unsigned reads_sent = 0;
  int unsigned txns_closed = 0;
  int unsigned cycle_count = 0;

  // Idling controls shared by the source and the sink
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned sink_hold_req = 0;
  int unsigned sink_stall_left = 0;

  spi_master_byte_shifter_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .tx_byte_i      (tx_byte_i),
    .miso_bits_i    (miso_bits_i),
    .end_after_i    (end_after_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .clock_pin_o    (clock_pin_o),
    .data_out_pin_o (data_out_pin_o),
    .select_pin_o   (select_pin_o),
    .rx_byte_o      (rx_byte_o),
    .last_o         (last_o)
  );

  // Toggle the clock every half period
  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pin states pending", cycle_count,
               expected_pins.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Pick an idle length: mostly none, some short, a few long
  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (pin state %0d)", $time,
               what, got_v, want_v, pins_checked);
    mismatches++;
  endtask

  // Expand one byte request into the pin states the master drives
  task automatic predict_pin_states(input item_t it);
    logic       idle_lvl;
    logic       lead_lvl;
    logic       trail_lvl;
    logic       final_bit;
    logic [7:0] rx_val;
    idle_lvl  = mode_shadow.cpol;
    lead_lvl  = mode_shadow.cpha ? ~idle_lvl : idle_lvl;
    trail_lvl = mode_shadow.cpha ? idle_lvl : ~idle_lvl;
    rx_val    = (it.req_type == REQ_READ) ? it.miso_bits : 8'h00;
    // Assert select first when no transaction is open
    if (!txn_open) begin
      expected_pins.push_back('{idle_lvl, held_mosi, mode_shadow.cs_level, 8'h00, 1'b0});
      txn_open = 1'b1;
    end
    // Shift MSB first; a read keeps the data line at its last level
    for (int b = ByteW - 1; b >= 0; b--) begin
      if (it.req_type == REQ_WRITE) held_mosi = it.tx_byte[b];
      final_bit = (b == 0) && !it.end_after;
      expected_pins.push_back('{lead_lvl, held_mosi, mode_shadow.cs_level, 8'h00, 1'b0});
      expected_pins.push_back('{trail_lvl, held_mosi, mode_shadow.cs_level,
                                final_bit ? rx_val : 8'h00, final_bit});
    end
    // Release select and return the clock to idle
    if (it.end_after) begin
      expected_pins.push_back('{idle_lvl, held_mosi, ~mode_shadow.cs_level, rx_val, 1'b1});
      txn_open = 1'b0;
      txns_closed++;
    end
  endtask

  // Offer one request after an optional gap and hold it until accepted
  task automatic send_request(input item_t it, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= it.req_type;
    tx_byte_i   <= it.tx_byte;
    miso_bits_i <= it.miso_bits;
    end_after_i <= it.end_after;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    // Accepted at the coming edge
    predict_pin_states(it);
    items_sent++;
    if (it.req_type == REQ_READ) reads_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_fields(input logic kind, input logic [7:0] tx, input logic [7:0] miso,
                             input logic fin);
    item_t it;
    it = '{kind, tx, miso, fin};
    send_request(it, src_idle_en ? random_gap() : 0);
  endtask

  // Drop valid and wait until every pin state has come out
  task automatic wait_for_pins();
    in_valid_i <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CPOL:     mode_shadow.cpol = val;
      CFG_CPHA:     mode_shadow.cpha = val;
      CFG_CS_LEVEL: mode_shadow.cs_level = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(input cfg_t m);
    write_register(CFG_CPOL, m.cpol);
    write_register(CFG_CPHA, m.cpha);
    write_register(CFG_CS_LEVEL, m.cs_level);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare each accepted pin state with the oldest prediction
  always @(negedge clk_i) begin : check_pins
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{clock_pin_o, data_out_pin_o, select_pin_o, rx_byte_o, last_o};
      if (expected_pins.size() == 0) begin
        report_mismatch("pin state with nothing pending", got.rx_byte, 8'h00);
      end else begin
        want = expected_pins.pop_front();
        if (got.clock_pin !== want.clock_pin)
          report_mismatch("clock_pin", 8'(got.clock_pin), 8'(want.clock_pin));
        if (got.data_out_pin !== want.data_out_pin)
          report_mismatch("data_out_pin", 8'(got.data_out_pin), 8'(want.data_out_pin));
        if (got.select_pin !== want.select_pin)
          report_mismatch("select_pin", 8'(got.select_pin), 8'(want.select_pin));
        if (got.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.last !== want.last)
          report_mismatch("last", 8'(got.last), 8'(want.last));
      end
      pins_checked++;
    end
  end

  // Drive the sink's ready: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (sink_hold_req != 0) begin
      sink_stall_left = sink_hold_req;
      sink_hold_req   = 0;
    end else if (sink_stall_left == 0 && sink_idle_en && out_ready_i) begin
      sink_stall_left = random_gap();
    end
    if (sink_stall_left != 0) begin
      out_ready_i <= 1'b0;
      sink_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Reset values: mode 0, select active low, data line held at 0
  task automatic test_reset_defaults();
    send_fields(REQ_READ, 8'hFF, 8'hFF, 1'b0);
    send_fields(REQ_WRITE, 8'h00, 8'hFF, 1'b0);
    send_fields(REQ_WRITE, 8'hFF, 8'h00, 1'b0);
    send_fields(REQ_READ, 8'h00, 8'h00, 1'b1);
    wait_for_pins();
  endtask

  // Every clock mode with both select levels
  task automatic test_all_modes();
    cfg_t m;
    for (int k = 0; k < 4; k++) begin
      m = '{k[1], k[0], k[0]};
      set_mode(m);
      send_fields(REQ_WRITE, 8'h80, 8'h00, 1'b0);
      send_fields(REQ_READ, 8'h00, 8'h5A, 1'b0);
      send_fields(REQ_WRITE, 8'h01, 8'hFF, 1'b1);
      wait_for_pins();
    end
    // Single-byte transactions: read shows its byte on the closing state
    send_fields(REQ_READ, 8'h3C, 8'hA5, 1'b1);
    send_fields(REQ_WRITE, 8'hFF, 8'h00, 1'b1);
    wait_for_pins();
  endtask

  // Change the mode, select level included, while the transaction stays open
  task automatic test_mode_change_open_txn();
    set_mode('{1'b0, 1'b0, 1'b1});
    send_fields(REQ_WRITE, 8'hC3, 8'h00, 1'b0);
    wait_for_pins();
    set_mode('{1'b1, 1'b1, 1'b0});
    send_fields(REQ_WRITE, 8'h3C, 8'h00, 1'b0);
    wait_for_pins();
    write_register(CFG_SPARE, 1'b1);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_fields(REQ_READ, 8'h00, 8'h81, 1'b1);
    wait_for_pins();
  endtask

  // Random transactions: a command byte, then reads and writes, then release, with some fully random requests mixed in
  task automatic run_random_txns(input int unsigned n_items);
    item_t       it;
    int unsigned bytes_left;
    bytes_left = 0;
    for (int k = 0; k < n_items; k++) begin
      it.tx_byte   = 8'($urandom_range(0, 255));
      it.miso_bits = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 12) begin
        it.req_type  = 1'($urandom_range(0, 1));
        it.end_after = 1'($urandom_range(0, 1));
      end else if (!txn_open) begin
        bytes_left   = $urandom_range(0, 4);
        it.req_type  = REQ_WRITE;
        it.end_after = (bytes_left == 0);
      end else begin
        if (bytes_left != 0) bytes_left--;
        it.req_type  = ($urandom_range(0, 9) < 6) ? REQ_READ : REQ_WRITE;
        it.end_after = (bytes_left == 0);
      end
      send_request(it, src_idle_en ? random_gap() : 0);
    end
  endtask

  task automatic test_random_phases();
    cfg_t m;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) m = '0;
      else if (p == 1) m = '1;
      else m = 3'($urandom_range(0, 7));
      wait_for_pins();
      set_mode(m);
      // Keep one phase free of idling on both sides
      src_idle_en  = (p != 2);
      sink_idle_en = (p != 2);
      run_random_txns(55);
    end
    wait_for_pins();
  endtask

  // Stall the sink long enough to back up the input, then drain fully
  task automatic test_backpressure();
    set_mode(3'($urandom_range(0, 7)));
    src_idle_en   = 1'b0;
    sink_hold_req = HOLD_OFF_CYCLES;
    run_random_txns(10);
    wait_for_pins();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    run_random_txns(10);
    wait_for_pins();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_all_modes();
    test_mode_change_open_txn();
    test_random_phases();
    test_backpressure();
    // Let any stray pin state show up
    wait_for_pins();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d byte requests (%0d reads) in %0d transactions", items_sent,
             reads_sent, txns_closed);
    $display("checked %0d pin states over all four clock modes, %0d mismatches",
             pins_checked, mismatches);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== spi_master_byte_shifter_core.f =====
hdl/smbs_pkg.sv
hdl/smbs_seq.sv
hdl/smbs_out_reg.sv
hdl/spi_master_byte_shifter_core.sv
test/testbench.sv
